/* rtl/core/q16m_pkg.sv */
// ----------------------------------------------------------------------------
// q16m_pkg
// Shared types, codes and helper functions of the Q16.16 math unit.
// ----------------------------------------------------------------------------
package q16m_pkg;

  localparam int unsigned FracBits = 16;

  typedef enum logic [2:0] {
    CMD_MUL  = 3'd0,
    CMD_DIV  = 3'd1,
    CMD_SQRT = 3'd2,
    CMD_CBRT = 3'd3,
    CMD_FLT  = 3'd4,
    CMD_ABS  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_DIVZ  = 2'd1,
    ERR_NOCNV = 2'd2
  } err_e;

  localparam logic [7:0]  FltBias  = 8'd134;
  localparam logic [31:0] RootSeed = 32'h0002_0000;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] from_float(input logic [31:0] bits);
    logic [7:0]  e;
    logic [8:0]  sh;
    logic [31:0] val;
    e   = bits[30:23] - FltBias;
    val = {8'h00, 1'b1, bits[22:0]};
    sh  = 9'd256 - {1'b0, e};
    if (e[7]) begin
      val = (sh >= 9'd32) ? 32'd0 : (val >> sh[4:0]);
    end else begin
      val = (e >= 8'd32) ? 32'd0 : (val << e[4:0]);
    end
    from_float = bits[31] ? (32'd0 - val) : val;
  endfunction

endpackage

/* rtl/core/q16m_mul.sv */
// ----------------------------------------------------------------------------
// q16m_mul
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle; returns
// product bits 47..16.
// ----------------------------------------------------------------------------
module q16m_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] p_o
);

  logic [47:0] mc_q;
  logic [31:0] mp_q;
  logic [47:0] acc_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [47:0] addend;

  assign addend = mp_q[0] ? mc_q : 48'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  // sign bit of the multiplier carries negative weight
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= {{16{a_i[31]}}, a_i};
      mp_q  <= b_i;
      acc_q <= 48'd0;
    end else if (busy_q) begin
      acc_q <= (cnt_q == 5'd31) ? (acc_q - addend) : (acc_q + addend);
      mc_q  <= {mc_q[46:0], 1'b0};
      mp_q  <= {1'b0, mp_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[47:16];

endmodule

/* rtl/core/q16m_div.sv */
// ----------------------------------------------------------------------------
// q16m_div
// Bit-serial restoring signed divider, truncating quotient and remainder
// with the sign of the dividend; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module q16m_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic [31:0] n_q;
  logic [31:0] d_q;
  logic [32:0] r_q;
  logic        qneg_q;
  logic        rneg_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] r_sh;
  logic        ge;

  assign r_sh = {r_q[31:0], n_q[31]};
  assign ge   = r_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= q16m_pkg::mag32(num_i);
      d_q    <= q16m_pkg::mag32(den_i);
      r_q    <= 33'd0;
      qneg_q <= num_i[31] ^ den_i[31];
      rneg_q <= num_i[31];
    end else if (busy_q) begin
      r_q <= ge ? (r_sh - {1'b0, d_q}) : r_sh;
      n_q <= {n_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = qneg_q ? (32'd0 - n_q) : n_q;
  assign rem_o  = rneg_q ? (32'd0 - r_q[31:0]) : r_q[31:0];

endmodule

/* rtl/core/q16_fixed_point_math_unit.sv */
// ----------------------------------------------------------------------------
// q16_fixed_point_math_unit
// Signed Q16.16 math unit: multiply, divide, square and cube root, float
// conversion and absolute value, one result word per request word.
// ----------------------------------------------------------------------------
// Request words enter on the s_axis channel (cmd in tuser, operands in
// tdata); one result word leaves on m_axis (value in tdata, error code in
// tuser). The cfg channel writes the Newton convergence threshold; the user
// is to write it only while the unit is idle, which the unit does not
// enforce itself; cfg_ready_o is always high. Float, absolute and unused
// commands go straight to the result; divide runs a serial quotient, then
// 16 fraction steps. Roots run Newton iterations built on the serial
// divider (square) or the serial multiplier and divider (cube), up to
// MAX_ITERATIONS times. One request is worked on at a time; the next is
// taken as soon as the result is parked in the output register, so a
// stalled receiver holds only the finished word. A further result waits
// inside until the output register drains. Reset clears the handshakes
// and sets the threshold to 6.
// ----------------------------------------------------------------------------
module q16_fixed_point_math_unit #(
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // operand_a[31:0], operand_b[63:32]
  input  logic [2:0]  s_axis_tuser_i,   // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // result_value[31:0]
  output logic [1:0]  m_axis_tuser_o,   // error_code[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IterW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_DEN  = 9'b000000100,
    ST_DIVQ = 9'b000001000,
    ST_FRAC = 9'b000010000,
    ST_STEP = 9'b000100000,
    ST_SDIV = 9'b001000000,
    ST_ROOT = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e      state_q;
  logic [15:0] thr_q;
  logic [2:0]  cmd_q;
  logic [31:0] a_q;
  logic [31:0] den_q;
  logic [31:0] t_q;
  logic [31:0] x_q;
  logic [31:0] r_q;
  logic [4:0]  fcnt_q;
  logic [IterW-1:0] iter_q;
  logic [31:0] res_q;
  logic [1:0]  code_q;
  logic        ov_q;
  logic [31:0] od_q;
  logic [1:0]  oc_q;

  logic        accept;
  logic        cube;
  logic        cap_hit;
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b, mul_p;
  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo, div_rem;
  logic [31:0] step_w, f_rem, f_x;
  logic        f_ge, f_neg;
  logic [31:0] t_new;

  assign accept          = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign cube            = (cmd_q == q16m_pkg::CMD_CBRT);
  assign cap_hit         = (iter_q == IterW'(MAX_ITERATIONS));

  assign mul_start = (accept && (s_axis_tuser_i == q16m_pkg::CMD_MUL)) ||
                     ((state_q == ST_ROOT) && !cap_hit && cube);
  assign mul_a     = (state_q == ST_IDLE) ? s_axis_tdata_i[31:0]  : t_q;
  assign mul_b     = (state_q == ST_IDLE) ? s_axis_tdata_i[63:32] : t_q;

  assign div_start = ((state_q == ST_DEN) && (den_q != 32'd0)) || (state_q == ST_STEP);
  assign div_num   = (state_q == ST_STEP) ? x_q : a_q;
  assign div_den   = (state_q == ST_STEP) ? (cube ? 32'd3 : 32'd2) : den_q;

  q16m_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  q16m_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // fraction step: the doubled remainder is below twice the divisor
  assign step_w = 32'd1 << (5'(q16m_pkg::FracBits) - fcnt_q);
  assign f_ge   = q16m_pkg::mag32(r_q) >= q16m_pkg::mag32(den_q);
  assign f_neg  = r_q[31] ^ den_q[31];
  assign f_rem  = !f_ge ? r_q : (f_neg ? (r_q + den_q) : (r_q - den_q));
  assign f_x    = !f_ge ? x_q : (f_neg ? (x_q - step_w) : (x_q + step_w));
  assign t_new  = t_q + div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= 16'd6;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if ((state_q == ST_DONE) && (!ov_q || m_axis_tready_i)) ov_q <= 1'b1;
      else if (ov_q && m_axis_tready_i) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            case (s_axis_tuser_i)
              q16m_pkg::CMD_MUL: state_q <= ST_MUL;
              q16m_pkg::CMD_DIV: state_q <= ST_DEN;
              q16m_pkg::CMD_SQRT, q16m_pkg::CMD_CBRT: state_q <= ST_ROOT;
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_MUL: begin
          if (mul_done) state_q <= (cmd_q == q16m_pkg::CMD_MUL) ? ST_DONE : ST_DEN;
        end
        ST_DEN:  state_q <= (den_q == 32'd0) ? ST_DONE : ST_DIVQ;
        ST_DIVQ: if (div_done) state_q <= ST_FRAC;
        ST_FRAC: begin
          if (fcnt_q == 5'(q16m_pkg::FracBits)) begin
            state_q <= (cmd_q == q16m_pkg::CMD_DIV) ? ST_DONE : ST_STEP;
          end
        end
        ST_STEP: state_q <= ST_SDIV;
        ST_SDIV: begin
          if (div_done) begin
            state_q <= (q16m_pkg::mag32(div_quo) <= {16'd0, thr_q}) ? ST_DONE : ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (cap_hit) state_q <= ST_DONE;
          else         state_q <= cube ? ST_MUL : ST_DEN;
        end
        ST_DONE: begin
          if (!ov_q || m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q  <= s_axis_tuser_i;
        a_q    <= s_axis_tdata_i[31:0];
        den_q  <= s_axis_tdata_i[63:32];
        t_q    <= q16m_pkg::RootSeed;
        iter_q <= '0;
        code_q <= q16m_pkg::ERR_OK;
        case (s_axis_tuser_i)
          q16m_pkg::CMD_FLT: res_q <= q16m_pkg::from_float(s_axis_tdata_i[31:0]);
          q16m_pkg::CMD_ABS: res_q <= q16m_pkg::mag32(s_axis_tdata_i[31:0]);
          default:           res_q <= 32'd0;
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          res_q <= mul_p;
          den_q <= mul_p;
        end
      end
      ST_DEN: begin
        if (den_q == 32'd0) begin
          res_q  <= 32'd0;
          code_q <= q16m_pkg::ERR_DIVZ;
        end
      end
      ST_DIVQ: begin
        if (div_done) begin
          x_q    <= div_quo << q16m_pkg::FracBits;
          r_q    <= div_rem << 1;
          fcnt_q <= 5'd1;
        end
      end
      ST_FRAC: begin
        x_q    <= (fcnt_q == 5'(q16m_pkg::FracBits)) ? (f_x - t_q) : f_x;
        r_q    <= f_rem << 1;
        fcnt_q <= fcnt_q + 5'd1;
        if (fcnt_q == 5'(q16m_pkg::FracBits)) begin
          res_q <= f_x;
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          t_q    <= t_new;
          res_q  <= t_new;
          iter_q <= iter_q + 1'b1;
        end
      end
      ST_ROOT: begin
        den_q <= t_q;
        if (cap_hit) begin
          res_q  <= t_q;
          code_q <= q16m_pkg::ERR_NOCNV;
        end
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready_i) begin
          od_q <= res_q;
          oc_q <= code_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = oc_q;

endmodule

/* sim/q16_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q16_result_checker
// Watches the request, result and threshold channels of the Q16.16 math
// unit, predicts each result word from the accepted request word and the
// current threshold, and compares value and error code in order.
// ----------------------------------------------------------------------------
module q16_result_checker #(
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          checked_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [31:0]    value;
    q16m_pkg::err_e err;
  } answer_t;

  answer_t     answers_q[$];
  logic [15:0] threshold;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] prod_q16(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p[47:16];
  endfunction

  function automatic logic [31:0] quot_q16(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] q, x, rem;
    q   = trunc_quot(a, b);
    x   = q << q16m_pkg::FracBits;
    rem = (a - q * b) << 1;
    for (int i = 1; i <= q16m_pkg::FracBits; i++) begin
      q   = trunc_quot(rem, b);
      x   = x + (q << (q16m_pkg::FracBits - i));
      rem = (rem - q * b) << 1;
    end
    return x;
  endfunction

  function automatic logic [31:0] float_to_q16(input logic [31:0] bits);
    logic [7:0]  e;
    logic [8:0]  sh;
    logic [31:0] val;
    e   = bits[30:23] - q16m_pkg::FltBias;
    val = {9'h001, bits[22:0]};
    if (e[7]) begin
      sh  = 9'd256 - {1'b0, e};
      val = (sh >= 9'd32) ? 32'd0 : val >> sh;
    end else begin
      val = (e >= 8'd32) ? 32'd0 : val << e;
    end
    return bits[31] ? -val : val;
  endfunction

  function automatic answer_t newton_root(input logic [31:0] x, input bit cube,
                                          input logic [15:0] thr);
    logic [31:0] t, den, dt;
    t = q16m_pkg::RootSeed;
    for (int n = 0; n < MAX_ITERATIONS; n++) begin
      den = cube ? prod_q16(t, t) : t;
      if (den == 32'd0) return answer_t'{32'd0, q16m_pkg::ERR_DIVZ};
      dt = trunc_quot(quot_q16(x, den) - t, cube ? 32'd3 : 32'd2);
      t  = t + dt;
      if (magnitude(dt) <= {16'd0, thr}) return answer_t'{t, q16m_pkg::ERR_OK};
    end
    return answer_t'{t, q16m_pkg::ERR_NOCNV};
  endfunction

  function automatic answer_t predict(input logic [2:0] cmd, input logic [31:0] a,
                                      input logic [31:0] b, input logic [15:0] thr);
    case (cmd)
      q16m_pkg::CMD_MUL:  return answer_t'{prod_q16(a, b), q16m_pkg::ERR_OK};
      q16m_pkg::CMD_DIV: begin
        if (b == 32'd0) return answer_t'{32'd0, q16m_pkg::ERR_DIVZ};
        return answer_t'{quot_q16(a, b), q16m_pkg::ERR_OK};
      end
      q16m_pkg::CMD_SQRT: return newton_root(a, 1'b0, thr);
      q16m_pkg::CMD_CBRT: return newton_root(a, 1'b1, thr);
      q16m_pkg::CMD_FLT:  return answer_t'{float_to_q16(a), q16m_pkg::ERR_OK};
      q16m_pkg::CMD_ABS:  return answer_t'{magnitude(a), q16m_pkg::ERR_OK};
      default:            return answer_t'{32'd0, q16m_pkg::ERR_OK};
    endcase
  endfunction

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_w;
    if (!rst_ni) begin
      threshold    <= 16'd6;
      checked_o    <= 0;
      fail_count_o <= 0;
      answers_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold <= cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i)
        answers_q.push_back(predict(s_axis_tuser_i, s_axis_tdata_i[31:0],
                                    s_axis_tdata_i[63:32], threshold));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        checked_o <= checked_o + 1;
        if (answers_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          $display("%0t: unexpected result word value %h err %0d", $realtime,
                   m_axis_tdata_i, m_axis_tuser_i);
        end else begin
          exp_w = answers_q.pop_front();
          if (exp_w.value !== m_axis_tdata_i || exp_w.err !== m_axis_tuser_i) begin
            fail_count_o <= fail_count_o + 1;
            $display("%0t: mismatch expected value %h err %0d, actual value %h err %0d",
                     $realtime, exp_w.value, exp_w.err, m_axis_tdata_i, m_axis_tuser_i);
          end
        end
      end
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random request words into the Q16.16 math unit under
// several convergence thresholds, with random idling on both channels and
// one long result stall; the checker scores every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         IDLE_PCT   = 26;
  localparam int         ITEMS_PER_PHASE = 220;
  localparam int         WATCHDOG_LIMIT  = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  int pending, checked, fails;
  int sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  q16_fixed_point_math_unit dut (.*);

  q16_result_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .pending_o(pending), .checked_o(checked), .fail_count_o(fails)
  );

  // receiver: random backpressure, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b);
    int gap;
    bit ok;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {b, a};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready_o;
      @(posedge clk_i);
    end while (!ok);
    sent++;
  endtask

  task automatic write_threshold(input logic [15:0] value);
    bit ok;
    s_axis_tvalid_i <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] any_operand();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(1) ? 32'hffff_ffff : 32'd0;
      3, 4:    return $urandom >> $urandom_range(31);
      5:       return -($urandom >> $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] a, b;
    int pick;
    a    = any_operand();
    b    = ($urandom_range(15) == 0) ? 32'd0 : any_operand();
    pick = $urandom_range(99);
    if (pick < 22)      send_word(q16m_pkg::CMD_MUL, a, b);
    else if (pick < 44) send_word(q16m_pkg::CMD_DIV, a, b);
    else if (pick < 56 || pick < 62) begin
      // roots: mostly positive radicands, a few negative ones
      a = $urandom >> $urandom_range(31, 1);
      if ($urandom_range(19) == 0) a = -a;
      send_word((pick < 56) ? q16m_pkg::CMD_SQRT : q16m_pkg::CMD_CBRT, a, b);
    end
    else if (pick < 82) send_word(q16m_pkg::CMD_FLT, $urandom, b);
    else if (pick < 96) send_word(q16m_pkg::CMD_ABS, a, b);
    else                send_word($urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7, a, b);
  endtask

  initial begin
    logic [15:0] thresholds [4];
    thresholds = '{16'd6, 16'd0, 16'hffff, 16'd0};
    thresholds[3] = $urandom_range(1, 4096);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, special cases
    send_word(q16m_pkg::CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(q16m_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(q16m_pkg::CMD_MUL, 32'hffff_ffff, 32'h0001_0000);
    send_word(q16m_pkg::CMD_DIV, 32'h0003_0000, 32'h0000_0000);
    send_word(q16m_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_0000);
    send_word(q16m_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(q16m_pkg::CMD_DIV, 32'h0001_0000, 32'h0003_0000);
    send_word(q16m_pkg::CMD_DIV, 32'hfff9_0000, 32'h0002_0000);
    send_word(q16m_pkg::CMD_SQRT, 32'h0000_0000, 32'd0);
    send_word(q16m_pkg::CMD_SQRT, 32'h0010_0000, 32'd0);
    send_word(q16m_pkg::CMD_SQRT, 32'h7fff_ffff, 32'd0);
    send_word(q16m_pkg::CMD_SQRT, 32'hfffc_0000, 32'd0);
    send_word(q16m_pkg::CMD_CBRT, 32'h001b_0000, 32'd0);
    send_word(q16m_pkg::CMD_CBRT, 32'h0000_0000, 32'd0);
    send_word(q16m_pkg::CMD_CBRT, 32'hfff8_0000, 32'hffff_ffff);
    send_word(q16m_pkg::CMD_FLT, 32'h0000_0000, 32'd0);
    send_word(q16m_pkg::CMD_FLT, 32'h0000_0001, 32'd0);
    send_word(q16m_pkg::CMD_FLT, 32'hbfc0_0000, 32'd0);
    send_word(q16m_pkg::CMD_FLT, 32'h7f80_0000, 32'd0);
    send_word(q16m_pkg::CMD_FLT, 32'h4b7f_ffff, 32'd0);
    send_word(q16m_pkg::CMD_FLT, 32'h3380_0000, 32'd0);
    send_word(q16m_pkg::CMD_ABS, 32'h8000_0000, 32'd0);
    send_word(q16m_pkg::CMD_ABS, 32'hffff_ffff, 32'd0);
    send_word(CMD_SPARE6, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_SPARE7, 32'h1234_5678, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) write_threshold(thresholds[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        calm = (ph == 2) && (n < 100);
        if (ph == 1 && n == 40) hold_req = 1'b1;
        send_random();
      end
    end
    calm = 1'b0;
    write_threshold(16'd6);
    repeat (30) send_random();
    s_axis_tvalid_i <= 1'b0;

    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    $display("sent %0d request words, scored %0d results over thresholds 6, 0, 65535, %0d",
             sent, checked, thresholds[3]);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fails);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
